// File: design/bdad_pkg.sv
// ----------------------------------------------------------------------------
// bdad_pkg: shared types and constants of the bitstream dpcm audio decoder
// Holds the configuration bundle, the queue entry between front and back,
// the result record and the register indexes of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package bdad_pkg;

  // block size limit, and field widths
  localparam int unsigned MaxBlockSamples = 65536;
  localparam int unsigned SampW           = 17;
  localparam int unsigned QueueDepth      = 4;
  localparam int unsigned QueuePtrW       = $clog2(QueueDepth);

  localparam logic [SampW-1:0] MAX_SAMPLES = SampW'(MaxBlockSamples);

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_STEREO = 2'd0,
    CFG_WIDE   = 2'd1,
    CFG_LEVEL  = 2'd2
  } cfg_idx_e;

  // configuration bundle
  typedef struct packed {
    logic       stereo;
    logic       wide;
    logic [2:0] level;
  } cfg_t;

  // one classified input byte waiting for the decoder
  typedef struct packed {
    logic [7:0]       data;
    logic             start;
    logic [SampW-1:0] samples;
    logic             last;
  } qent_t;

  // one decoded result
  typedef struct packed {
    logic [15:0] sample;
    logic [8:0]  rep;
    logic        chan;
    logic        last;
  } result_t;

endpackage

`default_nettype wire

// File: design/bdad_front.sv
// ----------------------------------------------------------------------------
// bdad_front: input side of the decoder
// Accepts compressed bytes, clamps the block size and queues them in a
// small fifo so the decoder can stall without blocking the input.
// ----------------------------------------------------------------------------
`default_nettype none

module bdad_front (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 byte_value_i,
  input  wire logic                       block_start_i,
  input  wire logic [bdad_pkg::SampW-1:0] block_samples_i,
  input  wire logic                       last_byte_i,
  output logic                            q_valid_o,
  output bdad_pkg::qent_t                 q_data_o,
  input  wire logic                       q_pop_i
);

  bdad_pkg::qent_t                    mem_q [bdad_pkg::QueueDepth];
  logic [bdad_pkg::QueuePtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [bdad_pkg::QueuePtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [bdad_pkg::QueuePtrW:0]       count_q, count_d;
  logic                               push;
  bdad_pkg::qent_t                    new_ent;

  // full fifo holds off the input
  assign in_stall_o = (count_q == (bdad_pkg::QueuePtrW+1)'(bdad_pkg::QueueDepth));
  assign push       = in_valid_i && !in_stall_o;
  assign q_valid_o  = (count_q != '0);
  assign q_data_o   = mem_q[rd_ptr_q];

  // classify: clamp the block size on block start bytes
  always_comb begin
    new_ent.data    = byte_value_i;
    new_ent.start   = block_start_i;
    new_ent.last    = last_byte_i;
    new_ent.samples = (block_samples_i > bdad_pkg::MAX_SAMPLES) ?
                      bdad_pkg::MAX_SAMPLES : block_samples_i;
  end

  // pointer and fill count update
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = rd_ptr_q + 1'b1;
    end
    case ({push, q_pop_i})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // fifo storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= new_ent;
    end
  end

endmodule

`default_nettype wire

// File: design/bdad_back.sv
// ----------------------------------------------------------------------------
// bdad_back: decoding engine of the decoder
// Pops queued bytes, loads block headers, feeds the bit buffer and decodes
// one code per cycle while the output is not stalled into an output register with its own handshake.
// ----------------------------------------------------------------------------
`default_nettype none

module bdad_back (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire bdad_pkg::cfg_t             cfg_i,
  input  wire logic                       q_valid_i,
  input  wire bdad_pkg::qent_t            q_data_i,
  output logic                            q_pop_o,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output bdad_pkg::result_t               out_o
);

  typedef enum logic [1:0] {
    ST_IDLE   = 2'b01,
    ST_DECODE = 2'b10
  } state_e;

  state_e                       st_q, st_d;
  logic [23:0]                  buf_q, buf_d;
  logic [4:0]                   cnt_q, cnt_d;
  logic [31:0]                  left_q, left_d;
  logic [31:0]                  right_q, right_d;
  logic                         chsel_q, chsel_d;
  logic [bdad_pkg::SampW-1:0]   samples_q, samples_d;
  logic [2:0]                   hdr_q, hdr_d;
  logic [7:0]                   hlow_q, hlow_d;
  logic [1:0]                   nres_q, nres_d;
  logic                         lastb_q, lastb_d;
  logic                         pend_valid_q, pend_valid_d;
  bdad_pkg::result_t            pend_q, pend_d;
  logic                         out_valid_q;
  bdad_pkg::result_t            out_q;

  logic                         emit;
  bdad_pkg::result_t            emit_res;
  logic                         emit_rdy;

  // code decoder signals
  logic [2:0]                   cl;
  logic [2:0]                   typ;
  logic                         dec_ok;
  logic [3:0]                   dec_len;
  logic [7:0]                   dec_run;
  logic                         dec_zero;
  logic                         dec_delta;
  logic [3:0]                   w;
  logic [3:0]                   s;
  logic [2:0]                   off;
  logic [2:0]                   wm1;
  logic [7:0]                   code8;
  logic [7:0]                   mag;
  logic [31:0]                  dlt;
  logic [31:0]                  cur_acc;
  logic [31:0]                  new_acc;
  logic [8:0]                   rep;
  logic [8:0]                   rep_cut;
  bdad_pkg::result_t            new_res;

  assign emit_rdy    = !out_valid_q || !out_stall_i;
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;
  assign cur_acc     = chsel_q ? right_q : left_q;

  // decode one code at the bottom of the bit buffer
  always_comb begin
    cl        = (cfg_i.level > 3'd5) ? 3'd5 : cfg_i.level;
    typ       = buf_q[2:0];
    dec_ok    = 1'b0;
    dec_len   = 4'd3;
    dec_run   = '0;
    dec_zero  = 1'b0;
    dec_delta = 1'b0;
    w         = 4'd2;
    s         = 4'd0;
    off       = 3'd3;
    if (cnt_q >= 5'd3) begin
      if (typ == 3'd7) begin
        if (cnt_q >= 5'd4) begin
          if (buf_q[3]) begin
            dec_zero = 1'b1;
            dec_len  = 4'd4;
            dec_ok   = 1'b1;
          end else begin
            w         = (cl >= 3'd3) ? 4'd8 : 4'd8 - {1'b0, cl};
            s         = (cl >= 3'd3) ? 4'd9 : 4'd9 + {1'b0, cl};
            off       = 3'd4;
            dec_len   = 4'd4 + w;
            dec_delta = 1'b1;
            dec_ok    = (cnt_q >= {1'b0, dec_len});
          end
        end
      end else if (typ != 3'd0) begin
        w         = (cl >= 3'd3) ? {1'b0, cl} + 4'd3 : 4'd5 - {1'b0, cl};
        s         = (cl >= 3'd3) ? 4'd1 + {1'b0, typ} : 4'd2 + {1'b0, typ} + {1'b0, cl};
        off       = 3'd3;
        dec_len   = 4'd3 + w;
        dec_delta = 1'b1;
        dec_ok    = (cnt_q >= {1'b0, dec_len});
      end else if (cl == 3'd5 && !cfg_i.stereo) begin
        // run length code, mono at the top level only
        if (cnt_q >= 5'd4) begin
          if (!buf_q[3]) begin
            dec_len = 4'd4;
            dec_ok  = 1'b1;
          end else if (cnt_q >= 5'd6) begin
            if (buf_q[5:4] != 2'd3) begin
              dec_run = {6'd0, buf_q[5:4]};
              dec_len = 4'd6;
              dec_ok  = 1'b1;
            end else begin
              dec_run = buf_q[13:6];
              dec_len = 4'd14;
              dec_ok  = (cnt_q >= 5'd14);
            end
          end
        end
      end else begin
        dec_len = 4'd3;
        dec_ok  = 1'b1;
      end
    end
  end

  // sign-magnitude delta applied to the current channel
  always_comb begin
    wm1   = 3'(w - 4'd1);
    code8 = 8'(buf_q >> off);
    mag   = code8 & 8'((9'd1 << wm1) - 9'd1);
    dlt   = 32'(mag) << s;
    if (dec_zero) begin
      new_acc = '0;
    end else if (dec_delta) begin
      new_acc = code8[wm1] ? cur_acc - dlt : cur_acc + dlt;
    end else begin
      new_acc = cur_acc;
    end
  end

  // result record, repeat count cut to the block budget
  always_comb begin
    rep     = {1'b0, dec_run} + 9'd1;
    rep_cut = ({8'd0, rep} > samples_q) ? samples_q[8:0] : rep;
    new_res.sample = cfg_i.wide ? new_acc[15:0] : {{8{new_acc[7]}}, new_acc[7:0]};
    new_res.rep    = rep_cut;
    new_res.chan   = chsel_q;
    new_res.last   = 1'b0;
  end

  // sequencer: pop a byte, then one code per cycle while the output can take it, then finish
  always_comb begin
    logic [bdad_pkg::SampW-1:0] s_e;
    logic [23:0]                b_e;
    logic [4:0]                 c_e;
    logic [31:0]                l_e;
    logic [31:0]                r_e;
    logic                       ch_e;
    logic [2:0]                 h_e;
    logic [7:0]                 hl_e;
    logic [2:0]                 hlen;
    logic [15:0]                hv;
    logic                       stop;

    st_d         = st_q;
    buf_d        = buf_q;
    cnt_d        = cnt_q;
    left_d       = left_q;
    right_d      = right_q;
    chsel_d      = chsel_q;
    samples_d    = samples_q;
    hdr_d        = hdr_q;
    hlow_d       = hlow_q;
    nres_d       = nres_q;
    lastb_d      = lastb_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    q_pop_o      = 1'b0;
    emit         = 1'b0;
    emit_res     = pend_q;
    s_e          = samples_q;
    b_e          = buf_q;
    c_e          = cnt_q;
    l_e          = left_q;
    r_e          = right_q;
    ch_e         = chsel_q;
    h_e          = hdr_q;
    hl_e         = hlow_q;
    hlen         = cfg_i.wide ? (cfg_i.stereo ? 3'd4 : 3'd2) : (cfg_i.stereo ? 3'd2 : 3'd1);
    hv           = {q_data_i.data, hlow_q};
    stop         = 1'b0;

    unique case (st_q)
      ST_IDLE: begin
        if (q_valid_i) begin
          q_pop_o = 1'b1;
          // block start restarts the decoder
          if (q_data_i.start) begin
            s_e  = q_data_i.samples;
            b_e  = '0;
            c_e  = '0;
            l_e  = '0;
            r_e  = '0;
            ch_e = 1'b0;
            h_e  = '0;
            hl_e = '0;
          end
          hv = {q_data_i.data, hl_e};
          if (s_e != '0 && h_e < hlen) begin
            // starting values, left channel first
            if (cfg_i.wide) begin
              if (!h_e[0]) begin
                hl_e = q_data_i.data;
              end else if (h_e[1]) begin
                r_e = {{16{hv[15]}}, hv};
              end else begin
                l_e = {{16{hv[15]}}, hv};
              end
            end else if (h_e[0]) begin
              r_e = {{24{q_data_i.data[7]}}, q_data_i.data};
            end else begin
              l_e = {{24{q_data_i.data[7]}}, q_data_i.data};
            end
            h_e = h_e + 3'd1;
          end else if (s_e != '0) begin
            // append the byte to the bit buffer
            if (c_e <= 5'd16) begin
              b_e = b_e | (24'(q_data_i.data) << c_e);
              c_e = c_e + 5'd8;
            end
            st_d    = ST_DECODE;
            nres_d  = '0;
            lastb_d = q_data_i.last;
          end
          if (st_d == ST_IDLE && q_data_i.last) begin
            s_e = '0;
            b_e = '0;
            c_e = '0;
          end
          samples_d = s_e;
          buf_d     = b_e;
          cnt_d     = c_e;
          left_d    = l_e;
          right_d   = r_e;
          chsel_d   = ch_e;
          hdr_d     = h_e;
          hlow_d    = hl_e;
        end
      end
      ST_DECODE: begin
        stop = (nres_q == 2'd3) || (samples_q == '0) || !dec_ok;
        if (!pend_valid_q || emit_rdy) begin
          emit          = pend_valid_q;
          emit_res      = pend_q;
          emit_res.last = stop;
          if (stop) begin
            // byte done: the held result closes it
            pend_valid_d = 1'b0;
            st_d         = ST_IDLE;
            if (lastb_q) begin
              samples_d = '0;
              buf_d     = '0;
              cnt_d     = '0;
            end
          end else begin
            pend_valid_d = 1'b1;
            pend_d       = new_res;
            buf_d        = buf_q >> dec_len;
            cnt_d        = cnt_q - {1'b0, dec_len};
            samples_d    = samples_q - {8'd0, rep_cut};
            chsel_d      = chsel_q ^ cfg_i.stereo;
            nres_d       = nres_q + 2'd1;
            if (chsel_q) begin
              right_d = new_acc;
            end else begin
              left_d = new_acc;
            end
          end
        end
      end
      default: begin
        st_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q         <= ST_IDLE;
      buf_q        <= '0;
      cnt_q        <= '0;
      left_q       <= '0;
      right_q      <= '0;
      chsel_q      <= 1'b0;
      samples_q    <= '0;
      hdr_q        <= '0;
      hlow_q       <= '0;
      nres_q       <= '0;
      lastb_q      <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      st_q         <= st_d;
      buf_q        <= buf_d;
      cnt_q        <= cnt_d;
      left_q       <= left_d;
      right_q      <= right_d;
      chsel_q      <= chsel_d;
      samples_q    <= samples_d;
      hdr_q        <= hdr_d;
      hlow_q       <= hlow_d;
      nres_q       <= nres_d;
      lastb_q      <= lastb_d;
      pend_valid_q <= pend_valid_d;
      if (emit) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (emit) begin
      out_q <= emit_res;
    end
  end

endmodule

`default_nettype wire

// File: design/bitstream_dpcm_audio_decoder_top.sv
// ----------------------------------------------------------------------------
// bitstream_dpcm_audio_decoder_top: block dpcm audio decoder
// Byte-fed decoder of block compressed audio with a small input fifo, a
// decoding engine and a registered result port.
// ----------------------------------------------------------------------------
// Bytes enter a four-entry fifo and are decoded one at a time. A header byte
// or an ignored byte is handled in the idle state alone; a data byte first
// enters the bit buffer, then yields one decoded code per cycle (up to three)
// while results are not stalled, and is then closed. This loop sets the
// byte rate; the fifo lets input flow on until it fills. The user must write
// configuration only while no byte is in flight; the block does not enforce it.
`default_nettype none

module bitstream_dpcm_audio_decoder_top (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       cfg_we_i,
  input  wire logic [1:0]                 cfg_index_i,
  input  wire logic [2:0]                 cfg_data_i,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [7:0]                 byte_value_i,
  input  wire logic                       block_start_i,
  input  wire logic [bdad_pkg::SampW-1:0] block_samples_i,
  input  wire logic                       last_byte_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic signed [15:0]              sample_o,
  output logic [8:0]                      repeat_count_o,
  output logic                            channel_o,
  output logic                            last_o
);

  bdad_pkg::cfg_t    cfg_q, cfg_d;
  logic              q_valid;
  bdad_pkg::qent_t   q_data;
  logic              q_pop;
  bdad_pkg::result_t res;

  // configuration registers
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (cfg_index_i)
        bdad_pkg::CFG_STEREO: cfg_d.stereo = cfg_data_i[0];
        bdad_pkg::CFG_WIDE:   cfg_d.wide   = cfg_data_i[0];
        bdad_pkg::CFG_LEVEL:  cfg_d.level  = cfg_data_i;
        default:              cfg_d        = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.stereo <= 1'b0;
      cfg_q.wide   <= 1'b1;
      cfg_q.level  <= 3'd2;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // input side with fifo
  bdad_front u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .byte_value_i    (byte_value_i),
    .block_start_i   (block_start_i),
    .block_samples_i (block_samples_i),
    .last_byte_i     (last_byte_i),
    .q_valid_o       (q_valid),
    .q_data_o        (q_data),
    .q_pop_i         (q_pop)
  );

  // decoding engine
  bdad_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg_q),
    .q_valid_i   (q_valid),
    .q_data_i    (q_data),
    .q_pop_o     (q_pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_o       (res)
  );

  assign sample_o       = res.sample;
  assign repeat_count_o = res.rep;
  assign channel_o      = res.chan;
  assign last_o         = res.last;

endmodule

`default_nettype wire

// File: verif/bitstream_dpcm_audio_decoder_top_tb.sv
// ----------------------------------------------------------------------------
// bitstream_dpcm_audio_decoder_top_tb: self-checking bench of the dpcm decoder
// Feeds compressed blocks byte by byte with random idling on both channels.
// A bit-exact decoder model predicts every sample transaction, and each
// accepted transaction is compared field by field against the oldest one.
// ----------------------------------------------------------------------------
module bitstream_dpcm_audio_decoder_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int TotalBytes   = 270;
  localparam int SettleCycles = 40;
  localparam int MaxGap       = 12;
  localparam int MaxPrinted   = 200;

  // code types whose meaning does not depend on the level
  localparam logic [2:0] CodeHold   = 3'd0;
  localparam logic [2:0] CodeEscape = 3'd7;
  // short run count that switches to the long form
  localparam logic [7:0] RunLong    = 8'd3;

  // dut ports
  logic                          clk_i           = 1'b0;
  logic                          rst_ni          = 1'b0;
  logic                          cfg_we_i        = 1'b0;
  logic [1:0]                    cfg_index_i     = bdad_pkg::CFG_STEREO;
  logic [2:0]                    cfg_data_i      = '0;
  logic                          in_valid_i      = 1'b0;
  logic                          in_stall_o;
  logic [7:0]                    byte_value_i    = '0;
  logic                          block_start_i   = 1'b0;
  logic [bdad_pkg::SampW-1:0]    block_samples_i = '0;
  logic                          last_byte_i     = 1'b0;
  logic                          out_valid_o;
  logic                          out_stall_i     = 1'b0;
  logic signed [15:0]            sample_o;
  logic [8:0]                    repeat_count_o;
  logic                          channel_o;
  logic                          last_o;

  // decoder model state
  bdad_pkg::cfg_t                cfg          = '{stereo: 1'b0, wide: 1'b1, level: 3'd2};
  logic [23:0]                   bit_buf      = '0;
  logic [4:0]                    bit_cnt      = '0;
  logic [31:0]                   acc [2]      = '{default: '0};
  logic                          chan         = 1'b0;
  logic [bdad_pkg::SampW-1:0]    samples_owed = '0;
  logic [2:0]                    hdr_seen     = '0;
  logic [7:0]                    hdr_low      = '0;

  // expected sample transactions, oldest first
  bdad_pkg::result_t             sample_q [$];
  int unsigned                   bad_fields   = 0;
  int unsigned                   sent_bytes   = 0;
  bit                            tx_calm      = 1'b0;
  bit                            rx_calm      = 1'b0;
  int                            stall_left   = 0;

  bitstream_dpcm_audio_decoder_top dut (.*);

  // clock
  always #4 clk_i = ~clk_i;

  // run limit
  initial begin : watchdog
    #3_000_000;
    $display("bitstream_dpcm_audio_decoder_top_tb failed");
    $finish;
  end

  function automatic int draw_gap(input bit calm);
    return calm ? 0 : int'($urandom_range(0, MaxGap));
  endfunction

  function automatic int header_len();
    return (cfg.wide ? 2 : 1) << cfg.stereo;
  endfunction

  function automatic logic [bdad_pkg::SampW-1:0] draw_samples();
    case ($urandom_range(0, 15))
      0: return bdad_pkg::SampW'($urandom_range(bdad_pkg::MaxBlockSamples,
                                                2**bdad_pkg::SampW - 1));
      1: return bdad_pkg::SampW'($urandom_range(100, 2000));
      default: return bdad_pkg::SampW'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [31:0] peek(input int off, input int n);
    return (32'(bit_buf) >> off) & ((32'd1 << n) - 32'd1);
  endfunction

  // sign-magnitude delta onto the current channel
  function automatic void add_delta(input logic [31:0] code, input int w, input int s);
    logic [31:0] mag;
    mag = (code & ((32'd1 << (w - 1)) - 32'd1)) << s;
    if (code[w-1]) acc[chan] = acc[chan] - mag;
    else acc[chan] = acc[chan] + mag;
  endfunction

  // consume one complete code, leave the buffer alone when bits are missing
  function automatic bit take_code(output logic [7:0] run);
    int         lvl;
    int         len;
    int         w;
    int         s;
    logic [2:0] kind;
    run  = '0;
    lvl  = (cfg.level > 3'd5) ? 5 : int'(cfg.level);
    if (bit_cnt < 5'd3) return 1'b0;
    kind = bit_buf[2:0];
    if (kind == CodeEscape) begin
      if (bit_cnt < 5'd4) return 1'b0;
      if (bit_buf[3]) begin
        len = 4;
        acc[chan] = '0;
      end else begin
        w   = (lvl >= 3) ? 8 : 8 - lvl;
        s   = (lvl >= 3) ? 9 : 9 + lvl;
        len = 4 + w;
        if (bit_cnt < len) return 1'b0;
        add_delta(peek(4, w), w, s);
      end
    end else if (kind != CodeHold) begin
      w   = (lvl >= 3) ? lvl + 3 : 5 - lvl;
      s   = (lvl >= 3) ? 1 + int'(kind) : 2 + int'(kind) + lvl;
      len = 3 + w;
      if (bit_cnt < len) return 1'b0;
      add_delta(peek(3, w), w, s);
    end else if (lvl == 5 && !cfg.stereo) begin
      // hold with optional run length
      if (bit_cnt < 5'd4) return 1'b0;
      if (!bit_buf[3]) begin
        len = 4;
      end else begin
        if (bit_cnt < 5'd6) return 1'b0;
        run = 8'(peek(4, 2));
        len = 6;
        if (run == RunLong) begin
          if (bit_cnt < 5'd14) return 1'b0;
          run = 8'(peek(6, 8));
          len = 14;
        end
      end
    end else begin
      len = 3;
    end
    bit_buf = bit_buf >> len;
    bit_cnt = bit_cnt - 5'(len);
    return 1'b1;
  endfunction

  // predict the transactions of one accepted byte
  function automatic void decode_byte(input logic [7:0] b, input logic opens,
                                      input logic [bdad_pkg::SampW-1:0] ns,
                                      input logic closes);
    bdad_pkg::result_t          batch [3];
    logic [7:0]                 run;
    logic [bdad_pkg::SampW-1:0] rep;
    logic [31:0]                v;
    logic [2:0]                 hdr_len;
    int                         n;
    n = 0;
    // block start clears the decoder
    if (opens) begin
      bit_buf      = '0;
      bit_cnt      = '0;
      acc[0]       = '0;
      acc[1]       = '0;
      chan         = 1'b0;
      hdr_seen     = '0;
      hdr_low      = '0;
      samples_owed = (ns > bdad_pkg::MAX_SAMPLES) ? bdad_pkg::MAX_SAMPLES : ns;
    end
    if (samples_owed != '0) begin
      hdr_len = 3'(header_len());
      if (hdr_seen < hdr_len) begin
        // starting values, low byte first for wide samples
        if (cfg.wide) begin
          if (!hdr_seen[0]) hdr_low = b;
          else acc[hdr_seen[1]] = {{16{b[7]}}, b, hdr_low};
        end else begin
          acc[hdr_seen[0]] = {{24{b[7]}}, b};
        end
        hdr_seen = hdr_seen + 3'd1;
      end else begin
        if (bit_cnt <= 5'd16) begin
          bit_buf = bit_buf | (24'(b) << bit_cnt);
          bit_cnt = bit_cnt + 5'd8;
        end
        while (n < 3 && samples_owed != '0) begin
          if (!take_code(run)) break;
          rep = bdad_pkg::SampW'(run) + 1'b1;
          if (rep > samples_owed) rep = samples_owed;
          v = acc[chan];
          batch[n].sample = cfg.wide ? v[15:0] : {{8{v[7]}}, v[7:0]};
          batch[n].rep    = 9'(rep);
          batch[n].chan   = chan;
          batch[n].last   = 1'b0;
          samples_owed    = samples_owed - rep;
          if (cfg.stereo) chan = ~chan;
          n++;
        end
      end
    end
    // last byte closes the block
    if (closes) begin
      samples_owed = '0;
      bit_buf      = '0;
      bit_cnt      = '0;
    end
    if (n > 0) batch[n-1].last = 1'b1;
    for (int i = 0; i < n; i++) sample_q.push_back(batch[i]);
  endfunction

  task automatic flag_mismatch(input string what, input int got, input int want);
    if (bad_fields < MaxPrinted)
      $display("%0t: %s mismatch: got %0d, expected %0d", $time, what, got, want);
    bad_fields++;
  endtask

  // result checking and receiver stall
  always @(posedge clk_i) begin : sample_sink
    bdad_pkg::result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (sample_q.size() == 0) begin
        flag_mismatch("sample with nothing pending", int'(sample_o), 0);
      end else begin
        want = sample_q.pop_front();
        if (sample_o !== want.sample)
          flag_mismatch("sample", int'(sample_o), int'($signed(want.sample)));
        if (repeat_count_o !== want.rep)
          flag_mismatch("repeat_count", int'(repeat_count_o), int'(want.rep));
        if (channel_o !== want.chan)
          flag_mismatch("channel", int'(channel_o), int'(want.chan));
        if (last_o !== want.last)
          flag_mismatch("last", int'(last_o), int'(want.last));
      end
      stall_left = draw_gap(rx_calm);
    end
    if (stall_left > 0) begin
      out_stall_i <= 1'b1;
      stall_left--;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  // one input transaction, returns at the edge that accepts it
  task automatic send_byte(input logic [7:0] b, input logic opens,
                           input logic [bdad_pkg::SampW-1:0] ns, input logic closes);
    int gap;
    gap = draw_gap(tx_calm);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    byte_value_i    <= b;
    block_start_i   <= opens;
    block_samples_i <= ns;
    last_byte_i     <= closes;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    decode_byte(b, opens, ns, closes);
    sent_bytes++;
  endtask

  // hold input until every pending sample is out
  task automatic drain(input bit settle);
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (sample_q.size() != 0);
    if (settle) repeat (SettleCycles) @(posedge clk_i);
  endtask

  // write all three registers once the decoder is quiet
  task automatic program_cfg(input logic [2:0] st, input logic [2:0] wd, input logic [2:0] lv);
    drain(1'b1);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= bdad_pkg::CFG_STEREO;
    cfg_data_i  <= st;
    @(posedge clk_i);
    cfg_index_i <= bdad_pkg::CFG_WIDE;
    cfg_data_i  <= wd;
    @(posedge clk_i);
    cfg_index_i <= bdad_pkg::CFG_LEVEL;
    cfg_data_i  <= lv;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    cfg.stereo  = st[0];
    cfg.wide    = wd[0];
    cfg.level   = lv;
  endtask

  task automatic send_block(input logic [7:0] data [$],
                            input logic [bdad_pkg::SampW-1:0] ns, input bit closed);
    foreach (data[k]) begin
      send_byte(data[k], k == 0, (k == 0) ? ns : bdad_pkg::SampW'($urandom),
                closed && (k == data.size() - 1));
      if (k + 1 < data.size() && $urandom_range(0, 15) == 0) drain(1'b0);
    end
  endtask

  // bytes outside any block produce nothing
  task automatic test_ignored_bytes();
    send_byte(8'hFF, 1'b0, '1, 1'b1);
    send_byte(8'h00, 1'b0, '0, 1'b0);
  endtask

  // mono level 5: long run of 256, run cut by the sample budget, spent block
  task automatic test_mono_runs();
    program_cfg(3'd0, 3'd1, 3'd5);
    send_block({8'h00, 8'h80, 8'hF8, 8'h3F, 8'h60, 8'hFF, 8'h0F}, 17'd258, 1'b1);
  endtask

  // stereo narrow level 0: header extremes, zero escapes, split wide delta
  task automatic test_stereo_narrow();
    program_cfg(3'd1, 3'd0, 3'd0);
    send_block({8'h7F, 8'h80, 8'hFF, 8'h77, 8'h80, 8'hD3}, 17'd20, 1'b1);
  endtask

  // levels above 5, oversized block, header-only block
  task automatic test_level_aliases();
    program_cfg(3'd1, 3'd1, 3'd7);
    send_block({8'hFF, 8'h7F, 8'h01, 8'h80, 8'h5A, 8'hA5}, '1, 1'b1);
    program_cfg(3'd0, 3'd0, 3'd6);
    send_block({8'h42}, 17'd1, 1'b1);
    send_byte(8'h99, 1'b0, bdad_pkg::SampW'($urandom), 1'b0);
  endtask

  // registers rewritten inside an open block
  task automatic test_mid_block_reconfig();
    program_cfg(3'd0, 3'd0, 3'd5);
    send_block({8'h10}, 17'd3000, 1'b0);
    repeat (8) begin
      repeat (3) send_byte(8'($urandom), 1'b0, bdad_pkg::SampW'($urandom), 1'b0);
      program_cfg(3'($urandom), 3'($urandom), ($urandom_range(0, 1) != 0) ? 3'd0 : 3'd5);
    end
    send_byte(8'($urandom), 1'b0, bdad_pkg::SampW'($urandom), 1'b1);
  endtask

  // random blocks under random settings, with stray bytes and cut blocks
  task automatic test_random_blocks();
    logic [7:0]  data [$];
    int          len;
    while (sent_bytes < TotalBytes) begin
      if ($urandom_range(0, 2) != 0)
        program_cfg(3'($urandom), 3'($urandom), 3'($urandom));
      tx_calm = ($urandom_range(0, 3) == 0);
      rx_calm = ($urandom_range(0, 3) == 0);
      if ($urandom_range(0, 7) == 0) begin
        repeat ($urandom_range(1, 6))
          send_byte(8'($urandom), $urandom_range(0, 3) == 0, draw_samples(),
                    $urandom_range(0, 3) == 0);
      end else begin
        data = {};
        len  = header_len() + int'($urandom_range(1, 14));
        repeat (len) data.push_back(8'($urandom));
        send_block(data, draw_samples(), $urandom_range(0, 9) != 0);
      end
    end
    tx_calm = 1'b0;
    rx_calm = 1'b0;
  endtask

  initial begin : test_sequence
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_ignored_bytes();
    test_mono_runs();
    test_stereo_narrow();
    test_level_aliases();
    test_mid_block_reconfig();
    test_random_blocks();
    drain(1'b1);
    if (bad_fields == 0) begin
      $display("bitstream_dpcm_audio_decoder_top_tb passed");
    end else begin
      $display("bitstream_dpcm_audio_decoder_top_tb failed");
    end
    $finish;
  end

endmodule

// File: files.f
design/bdad_pkg.sv
design/bdad_front.sv
design/bdad_back.sv
design/bitstream_dpcm_audio_decoder_top.sv
verif/bitstream_dpcm_audio_decoder_top_tb.sv
